// ===== rtl/core/pclab_pkg.sv =====
// Shared types and constants for the percolation cluster labeler.
`timescale 1ns / 1ps

package pclab_pkg;

   // Lattice geometry.
   localparam int SIDE    = 32;
   localparam int SITES   = SIDE * SIDE;
   localparam int ADDR_W  = $clog2(SITES);
   localparam int COORD_W = $clog2(SIDE);

   // Field widths fixed by the interface.
   localparam int FIELD_W = 5;
   localparam int LABEL_W = 11;
   localparam int COUNT_W = 11;

   // Neighbor slots, in the order the merge visits them.
   localparam int NUM_NB = 4;
   localparam int NB_W   = 2;
   localparam logic [NB_W-1:0] NB_LEFT  = 2'd0;
   localparam logic [NB_W-1:0] NB_ABOVE = 2'd1;
   localparam logic [NB_W-1:0] NB_RIGHT = 2'd2;
   localparam logic [NB_W-1:0] NB_BELOW = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] site_col;
      logic [FIELD_W-1:0] site_row;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] site_label;
      logic               newly_filled;
      logic [COUNT_W-1:0] filled_total;
      logic [COUNT_W-1:0] cluster_size;
      logic               spans;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_SITE,
      ST_SITE_CHK,
      ST_NB,
      ST_SWEEP,
      ST_TAIL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic            load_req;
      logic            site_rd;
      logic            site_chk;
      logic            nb_rd;
      logic [NB_W-1:0] nb_rd_idx;
      logic            nb_cap;
      logic [NB_W-1:0] nb_cap_idx;
      logic            sweep_rd;
      logic            clear_wr;
      logic            rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic sweep_last;
   } status_type;

endpackage

// ===== rtl/core/pclab_datapath.sv =====
// Datapath of the labeler: lattice memory, label registers, sweep counters and result register.
`timescale 1ns / 1ps

module pclab_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pclab_pkg::req_type   req_payload,
   input  pclab_pkg::cmd_type   cmd,
   output pclab_pkg::status_type status,
   output pclab_pkg::rsp_type   rsp_payload
);
   import pclab_pkg::*;

   logic [LABEL_W-1:0] lattice_ff [SITES];
   logic [LABEL_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [LABEL_W-1:0] wr_data;

   logic [FIELD_W-1:0] col_ff;
   logic [FIELD_W-1:0] row_ff;
   logic               in_range_ff;
   logic [ADDR_W-1:0]  here_ff;

   logic [LABEL_W-1:0] next_label_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [LABEL_W-1:0] lab_ff;
   logic               fresh_ff;
   logic [LABEL_W-1:0] nb_lab_ff [NUM_NB];
   logic [COUNT_W-1:0] size_ff;
   logic               edge_bot_ff, edge_top_ff, edge_lft_ff, edge_rgt_ff;

   logic [ADDR_W-1:0]  sw_addr_ff;
   logic [COORD_W-1:0] sw_col_ff, sw_row_ff;
   logic               pend_ff;
   logic [ADDR_W-1:0]  pend_addr_ff;
   logic [COORD_W-1:0] pend_col_ff, pend_row_ff;

   logic [ADDR_W-1:0]  nb_addr [NUM_NB];
   logic [NUM_NB-1:0]  nb_ok;
   logic               hit;
   logic [LABEL_W-1:0] new_val;
   logic               in_range;

   rsp_type rsp_ff;

   assign in_range = (int'(req_payload.site_col) < SIDE) && (int'(req_payload.site_row) < SIDE);

   // Neighbors of the current site and whether they lie inside the lattice.
   always_comb begin
      nb_addr[NB_LEFT]  = ADDR_W'(int'(here_ff) - SIDE);
      nb_addr[NB_ABOVE] = ADDR_W'(int'(here_ff) + 1);
      nb_addr[NB_RIGHT] = ADDR_W'(int'(here_ff) + SIDE);
      nb_addr[NB_BELOW] = ADDR_W'(int'(here_ff) - 1);
      nb_ok[NB_LEFT]    = (col_ff != '0);
      nb_ok[NB_ABOVE]   = (int'(row_ff) < SIDE - 1);
      nb_ok[NB_RIGHT]   = (int'(col_ff) < SIDE - 1);
      nb_ok[NB_BELOW]   = (row_ff != '0);
   end

   // Any nonzero captured neighbor label turns into the site's label.
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_NB; i++) begin
         if (nb_lab_ff[i] != '0 && rd_data_ff == nb_lab_ff[i]) begin
            hit = 1'b1;
         end
      end
      new_val = hit ? lab_ff : rd_data_ff;
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = sw_addr_ff;
      if (cmd.site_rd) begin
         rd_en   = 1'b1;
         rd_addr = here_ff;
      end else if (cmd.nb_rd) begin
         rd_en   = nb_ok[cmd.nb_rd_idx];
         rd_addr = nb_addr[cmd.nb_rd_idx];
      end else if (cmd.sweep_rd) begin
         rd_en   = 1'b1;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sw_addr_ff;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
      end else if (cmd.site_chk) begin
         wr_en   = (rd_data_ff == '0);
         wr_addr = here_ff;
         wr_data = next_label_ff;
      end else if (pend_ff) begin
         wr_en   = hit;
         wr_addr = pend_addr_ff;
         wr_data = lab_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= lattice_ff[rd_addr];
      end
      if (wr_en) begin
         lattice_ff[wr_addr] <= wr_data;
      end
   end

   // Sweep address and coordinate counters, shared by the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_addr_ff <= '0;
         sw_col_ff  <= '0;
         sw_row_ff  <= '0;
         pend_ff    <= 1'b0;
      end else begin
         pend_ff <= cmd.sweep_rd;
         if (cmd.sweep_rd || cmd.clear_wr) begin
            if (status.sweep_last) begin
               sw_addr_ff <= '0;
               sw_col_ff  <= '0;
               sw_row_ff  <= '0;
            end else begin
               sw_addr_ff <= sw_addr_ff + ADDR_W'(1);
               if (int'(sw_row_ff) == SIDE - 1) begin
                  sw_row_ff <= '0;
                  sw_col_ff <= sw_col_ff + COORD_W'(1);
               end else begin
                  sw_row_ff <= sw_row_ff + COORD_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= sw_addr_ff;
      pend_col_ff  <= sw_col_ff;
      pend_row_ff  <= sw_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_label_ff <= LABEL_W'(1);
         count_ff      <= '0;
      end else if (cmd.site_chk && rd_data_ff == '0) begin
         next_label_ff <= next_label_ff + LABEL_W'(1);
         count_ff      <= count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         col_ff      <= req_payload.site_col;
         row_ff      <= req_payload.site_row;
         in_range_ff <= in_range;
         here_ff     <= ADDR_W'(int'(req_payload.site_col) * SIDE + int'(req_payload.site_row));
         lab_ff      <= '0;
         fresh_ff    <= 1'b0;
         size_ff     <= '0;
         edge_bot_ff <= 1'b0;
         edge_top_ff <= 1'b0;
         edge_lft_ff <= 1'b0;
         edge_rgt_ff <= 1'b0;
      end
      if (cmd.site_chk) begin
         fresh_ff <= (rd_data_ff == '0);
         lab_ff   <= (rd_data_ff == '0) ? next_label_ff : rd_data_ff;
      end
      if (cmd.nb_cap) begin
         nb_lab_ff[cmd.nb_cap_idx] <= nb_ok[cmd.nb_cap_idx] ? rd_data_ff : '0;
      end
      if (pend_ff && new_val == lab_ff) begin
         size_ff <= size_ff + COUNT_W'(1);
         if (pend_row_ff == '0) edge_bot_ff <= 1'b1;
         if (int'(pend_row_ff) == SIDE - 1) edge_top_ff <= 1'b1;
         if (pend_col_ff == '0) edge_lft_ff <= 1'b1;
         if (int'(pend_col_ff) == SIDE - 1) edge_rgt_ff <= 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_ff.site_label   <= lab_ff;
         rsp_ff.newly_filled <= fresh_ff;
         rsp_ff.filled_total <= count_ff;
         rsp_ff.cluster_size <= size_ff;
         rsp_ff.spans        <= edge_bot_ff & edge_top_ff & edge_lft_ff & edge_rgt_ff;
      end
   end

   assign status.in_range   = in_range_ff;
   assign status.sweep_last = (int'(sw_addr_ff) == SITES - 1);
   assign rsp_payload       = rsp_ff;

endmodule

// ===== rtl/core/pclab_ctrl.sv =====
// Controller state machine of the labeler: sequencing and handshakes.
`timescale 1ns / 1ps

module pclab_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pclab_pkg::status_type status,
   output pclab_pkg::cmd_type    cmd
);
   import pclab_pkg::*;

   state_type    state_ff, state_in;
   logic [2:0]   nb_step_ff, nb_step_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         nb_step_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nb_step_ff   <= nb_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      nb_step_in = nb_step_ff;
      cmd        = '0;
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_RD_SITE;
            end
         end
         ST_RD_SITE: begin
            if (status.in_range) begin
               cmd.site_rd = 1'b1;
               state_in    = ST_SITE_CHK;
            end else begin
               state_in    = ST_DONE;
            end
         end
         ST_SITE_CHK: begin
            cmd.site_chk = 1'b1;
            nb_step_in   = '0;
            state_in     = ST_NB;
         end
         ST_NB: begin
            // Neighbor reads are pipelined: issue slot n while capturing slot n-1.
            cmd.nb_rd      = (nb_step_ff < 3'd4);
            cmd.nb_rd_idx  = nb_step_ff[NB_W-1:0];
            cmd.nb_cap     = (nb_step_ff != '0);
            cmd.nb_cap_idx = NB_W'(nb_step_ff - 3'd1);
            nb_step_in     = nb_step_ff + 3'd1;
            if (nb_step_ff == 3'd4) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            if (status.sweep_last) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/percolation_cluster_labeler_core.sv =====
// Most of each request is the single relabel-and-count sweep through the lattice memory,
// one entry per cycle on its read port.
// Requests are taken one at a time, each only once the last is done; the next is taken
// while a result waits in the output register.
// Reset: synchronous; afterwards a clearing pass zeroes all SIDE*SIDE entries of the lattice
// memory, and requests are stalled until it ends.
`timescale 1ns / 1ps

module percolation_cluster_labeler_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pclab_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pclab_pkg::rsp_type  rsp_payload
);
   import pclab_pkg::*;

   cmd_type    cmd;
   status_type status;

   pclab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pclab_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/pclab_checker.sv =====
// Port-level checker for the labeler core and its bind statement.
`timescale 1ns / 1ps

module pclab_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input pclab_pkg::rsp_type  rsp_payload
);
   import pclab_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Only one request is in work: the core stalls right after taking one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // A placed site always belongs to a cluster of at least itself.
   a_label_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.site_label != '0) == (rsp_payload.cluster_size != '0)))
      else $error("label and cluster size disagree");

   // A new fill counts toward the total.
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.newly_filled |->
         rsp_payload.filled_total != '0 && rsp_payload.site_label != '0)
      else $error("new fill without count or label");

endmodule

bind percolation_cluster_labeler_core pclab_checker u_pclab_checker (.*);
